// ===== hw/rtl/shs_pkg.sv =====
// shared types, constants and helper functions of the sha-256 stream hasher
// no dependencies; the top level, block store and round core use this package by scoped names
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [6:0]  LenPos     = 7'd56;
  localparam logic [6:0]  BlockBytes = 7'd64;
  localparam logic [6:0]  NoPad      = 7'd64;

  localparam word_t RoundK [Rounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // how the block store is read out for one compression
  typedef struct packed {
    logic [6:0] valid_bytes;  // bytes taken from the store
    logic [6:0] pad_pos;      // byte position of the pad marker, NoPad if none
    logic       add_len;      // last two words carry the message bit length
  } blk_mode_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  // one byte write into the block store
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } byte_wr_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hw/rtl/shs_if.sv =====
// channel interfaces of the sha-256 stream hasher: byte input and digest output
// depends on nothing but the language
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// top level of the sha-256 stream hasher: sequencer, chaining value, digest output
// uses shs_pkg, shs_if, shs_block_ram and shs_round_core
//
// msg_i takes one beat per message byte (byte_present) and a beat with
// end_of_message closes the message; a bare end beat hashes what is held,
// so an empty message works. dig_o gives eight beats of 32-bit digest words,
// word_index 0 first, last_word on the eighth.
// A byte beat that does not fill a block is taken without a compression.
// The beat that fills 64 bytes starts a compression (a read to prime the
// block store, 64 rounds, a fold into the chaining value), during which
// msg_i is not ready; the single round unit, one round a cycle, sets its pace.
// An end beat costs one compression, or two when fewer than nine bytes of
// room remain, also when its own byte fills the block; the first
// digest beat is shown the cycle after the last fold.
// While digest beats wait, msg_i stays not ready; a stalled dig_o holds its
// beat. After the eighth beat the chaining value returns to the initial
// hash, ready for the next message.
// Reset clears the sequencer, fill level, bit count and chaining value; no
// clearing pass is needed, the block store is only read where written.
module sha256_stream_hasher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  shs_in_if.sink     msg_i,
  shs_out_if.source  dig_o
);

  typedef enum logic [2:0] {
    StIdle,
    StPrime,
    StRound,
    StAdd,
    StEmit
  } state_e;

  state_e              state_q;
  logic [5:0]          fill_q;
  logic [63:0]         bits_q;
  shs_pkg::hash_t      chain_q;
  logic [5:0]          rnd_q;
  shs_pkg::blk_mode_t  mode_q;
  logic                fin_q;
  logic                pend_q;
  logic [6:0]          pend_pad_q;
  logic [2:0]          idx_q;

  logic                in_beat;
  logic                out_beat;
  logic [6:0]          fill_inc;
  logic [6:0]          fill_end;
  shs_pkg::byte_wr_t   wr;
  logic                rd_en;
  logic [3:0]          rd_addr;
  shs_pkg::rnd_ctrl_t  ctrl;
  shs_pkg::word_t      mem_word;
  shs_pkg::hash_t      vars;

  // handshakes
  assign msg_i.ready = (state_q == StIdle);
  assign in_beat     = msg_i.valid && msg_i.ready;
  assign out_beat    = dig_o.valid && dig_o.ready;

  // fill after this beat's byte, and the fill the end beat pads from
  assign fill_inc = {1'b0, fill_q} + 7'd1;
  assign fill_end = msg_i.byte_present ? fill_inc : {1'b0, fill_q};

  // byte writes go into the store only while idle, reads only while hashing
  assign wr.en   = in_beat && msg_i.byte_present;
  assign wr.addr = fill_q;
  assign wr.data = msg_i.data_byte;

  assign rd_en   = (state_q == StPrime) || (state_q == StRound && rnd_q < 6'd15);
  assign rd_addr = (state_q == StPrime) ? 4'd0 : rnd_q[3:0] + 4'd1;

  assign ctrl.load = (state_q == StPrime);
  assign ctrl.step = (state_q == StRound);
  assign ctrl.rnd  = rnd_q;

  shs_block_ram u_ram (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .mode_i     (mode_q),
    .msg_bits_i (bits_q),
    .word_o     (mem_word)
  );

  shs_round_core u_core (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .chain_i    (chain_q),
    .mem_word_i (mem_word),
    .vars_o     (vars)
  );

  // sequencer with chaining value and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      fill_q     <= '0;
      bits_q     <= '0;
      rnd_q      <= '0;
      mode_q     <= '0;
      fin_q      <= 1'b0;
      pend_q     <= 1'b0;
      pend_pad_q <= shs_pkg::NoPad;
      idx_q      <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= shs_pkg::InitHash[i];
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            if (msg_i.byte_present) begin
              bits_q <= bits_q + 64'd8;
            end
            if (msg_i.byte_present && fill_inc == shs_pkg::BlockBytes) begin
              // full block; with an end beat, a block of pad and length follows
              mode_q     <= '{valid_bytes: shs_pkg::BlockBytes,
                              pad_pos: shs_pkg::NoPad, add_len: 1'b0};
              fin_q      <= 1'b0;
              pend_q     <= msg_i.end_of_message;
              pend_pad_q <= 7'd0;
              fill_q     <= '0;
              state_q    <= StPrime;
            end else if (msg_i.end_of_message) begin
              fill_q <= '0;
              if (fill_end >= shs_pkg::LenPos) begin
                // no room for the length: pad here, length in an extra block
                mode_q     <= '{valid_bytes: fill_end, pad_pos: fill_end, add_len: 1'b0};
                fin_q      <= 1'b0;
                pend_q     <= 1'b1;
                pend_pad_q <= shs_pkg::NoPad;
              end else begin
                mode_q <= '{valid_bytes: fill_end, pad_pos: fill_end, add_len: 1'b1};
                fin_q  <= 1'b1;
                pend_q <= 1'b0;
              end
              state_q <= StPrime;
            end else if (msg_i.byte_present) begin
              fill_q <= fill_inc[5:0];
            end
          end
        end
        StPrime: begin
          rnd_q   <= '0;
          state_q <= StRound;
        end
        StRound: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'(shs_pkg::Rounds - 1)) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + vars[i];
          end
          if (fin_q) begin
            idx_q   <= '0;
            state_q <= StEmit;
          end else if (pend_q) begin
            mode_q  <= '{valid_bytes: 7'd0, pad_pos: pend_pad_q, add_len: 1'b1};
            fin_q   <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= StPrime;
          end else begin
            state_q <= StIdle;
          end
        end
        StEmit: begin
          if (out_beat) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain_q[i] <= shs_pkg::InitHash[i];
              end
              bits_q  <= '0;
              fill_q  <= '0;
              fin_q   <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // digest beats straight from the chaining value
  assign dig_o.valid       = (state_q == StEmit);
  assign dig_o.digest_word = chain_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == 3'd7);

endmodule

// ===== hw/rtl/shs_block_ram.sv =====
// block store: 16 words of 4 byte lanes, byte writes, registered word reads
// read data is shaped with pad marker, zero fill and bit length; uses shs_pkg
module shs_block_ram (
  input  logic                clk_i,
  input  shs_pkg::byte_wr_t   wr_i,
  input  logic                rd_en_i,
  input  logic [3:0]          rd_addr_i,
  input  shs_pkg::blk_mode_t  mode_i,
  input  logic [63:0]         msg_bits_i,
  output shs_pkg::word_t      word_o
);

  logic [3:0][7:0] mem_q [shs_pkg::BlockWords];
  logic [3:0][7:0] rdata_q;
  logic [3:0]      raddr_q;

  // byte lane 3 holds the first byte of a word (big-endian)
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[5:2]][2'd3 - wr_i.addr[1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      raddr_q <= rd_addr_i;
    end
  end

  // message bytes below the fill, then the pad marker, zeros, and the length
  always_comb begin
    logic [6:0] pos;
    for (int b = 0; b < 4; b++) begin
      pos = {1'b0, raddr_q, 2'(b)};
      if (pos < mode_i.valid_bytes) begin
        word_o[31 - 8 * b -: 8] = rdata_q[3 - b];
      end else if (pos == mode_i.pad_pos) begin
        word_o[31 - 8 * b -: 8] = shs_pkg::PadByte;
      end else begin
        word_o[31 - 8 * b -: 8] = 8'h00;
      end
    end
    if (mode_i.add_len && raddr_q == 4'd14) begin
      word_o = msg_bits_i[63:32];
    end else if (mode_i.add_len && raddr_q == 4'd15) begin
      word_o = msg_bits_i[31:0];
    end
  end

endmodule

// ===== hw/rtl/shs_round_core.sv =====
// one sha-256 round per cycle with a 16-word message schedule window
// takes words from the block store for rounds 0 to 15; uses shs_pkg
module shs_round_core (
  input  logic                clk_i,
  input  shs_pkg::rnd_ctrl_t  ctrl_i,
  input  shs_pkg::hash_t      chain_i,
  input  shs_pkg::word_t      mem_word_i,
  output shs_pkg::hash_t      vars_o
);

  shs_pkg::hash_t         vars_q;
  shs_pkg::word_t [15:0]  win_q;   // win_q[0] is the oldest word, w[t-16]
  shs_pkg::word_t         w_sched;
  shs_pkg::word_t         w_cur;
  shs_pkg::word_t         t1;
  shs_pkg::word_t         t2;
  shs_pkg::word_t         ch;
  shs_pkg::word_t         maj;

  // schedule expansion from the window, block words for the first 16 rounds
  assign w_sched = win_q[0] + shs_pkg::small_sigma0(win_q[1]) + win_q[9]
                 + shs_pkg::small_sigma1(win_q[14]);
  assign w_cur   = (ctrl_i.rnd < 6'd16) ? mem_word_i : w_sched;

  // round function, index 0 is a and index 7 is h
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + shs_pkg::big_sigma1(vars_q[4]) + ch
             + shs_pkg::RoundK[ctrl_i.rnd] + w_cur;
  assign t2  = shs_pkg::big_sigma0(vars_q[0]) + maj;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vars_q <= chain_i;
    end else if (ctrl_i.step) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
      win_q     <= {w_cur, win_q[15:1]};
    end
  end

  assign vars_o = vars_q;

endmodule

// ===== hw/rtl/shs_port_checker.sv =====
// port-level checks of the sha-256 stream hasher, bound to the top level
// depends on sha256_stream_hasher_unit and its channel interfaces
module shs_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  // a stalled digest beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digest_word_i)
                                    && $stable(word_index_i))
    else $error("digest beat changed while stalled");

  // last flag marks exactly the eighth word
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 3'd7)))
    else $error("last_word does not match word_index");

  // words follow one another without gaps in index
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_word_i
      |=> out_valid_i && (word_index_i == 3'($past(word_index_i) + 3'd1)))
    else $error("digest word index did not advance by one");

  // the digest ends after its last word
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_word_i |=> !out_valid_i)
    else $error("digest beats continued past the last word");

  // no byte taken while the digest drains
  a_no_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while digest pending");

endmodule

bind sha256_stream_hasher_unit shs_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (msg_i.ready),
  .out_valid_i   (dig_o.valid),
  .out_ready_i   (dig_o.ready),
  .digest_word_i (dig_o.digest_word),
  .word_index_i  (dig_o.word_index),
  .last_word_i   (dig_o.last_word)
);

// ===== tb/shs_digest_checker.sv =====
// digest checker of the sha-256 stream hasher testbench: watches both channels,
// predicts every digest beat and compares it; depends on shs_if only
`timescale 1ns / 100ps

module shs_digest_checker (
  input  logic clk_i,
  input  logic rst_ni,
  shs_in_if    msg,
  shs_out_if   dig,
  output int   fail_count_o,
  output int   pending_o
);

  // one digest beat as the output channel carries it
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam int unsigned LenStart = 56;

  logic [31:0]  hash_state [8];
  logic [7:0]   block_buf [64];
  int unsigned  fill_cnt;
  logic [63:0]  bit_len;
  digest_beat_t digest_q [$];
  digest_beat_t got_beat;
  digest_beat_t want_beat;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // 64 rounds over the held block, folded into the hash state
  function automatic void compress_held_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) begin
      hash_state[i] = StartHash[i];
    end
    fill_cnt = 0;
    bit_len  = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    block_buf[fill_cnt] = data;
    fill_cnt++;
    bit_len += 64'd8;
    if (fill_cnt == 64) begin
      compress_held_block();
      fill_cnt = 0;
    end
  endfunction

  // pad, length, final compression(s), then queue the eight digest beats
  function automatic void close_message();
    block_buf[fill_cnt] = PadMarker;
    fill_cnt++;
    if (fill_cnt > LenStart) begin
      for (int i = fill_cnt; i < 64; i++) begin
        block_buf[i] = 8'h00;
      end
      compress_held_block();
      fill_cnt = 0;
    end
    for (int i = fill_cnt; i < LenStart; i++) begin
      block_buf[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      block_buf[63-i] = bit_len[8*i +: 8];
    end
    compress_held_block();
    for (int i = 0; i < 8; i++) begin
      digest_q.push_back('{hash_state[i], 3'(i), (i == 7)});
    end
    restart_message();
  endfunction

  // compare digest beats first, then feed accepted message beats to the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_q.delete();
      fail_count_o = 0;
    end else begin
      if (dig.valid && dig.ready) begin
        got_beat = {dig.digest_word, dig.word_index, dig.last_word};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat: word %h index %0d last %0b",
                   $time, got_beat.word, got_beat.idx, got_beat.last);
          fail_count_o++;
        end else begin
          want_beat = digest_q.pop_front();
          if (got_beat !== want_beat) begin
            $display("%0t: digest mismatch: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                     $time, want_beat.word, want_beat.idx, want_beat.last,
                     got_beat.word, got_beat.idx, got_beat.last);
            fail_count_o++;
          end
        end
      end
      if (msg.valid && msg.ready) begin
        if (msg.byte_present) begin
          absorb_byte(msg.data_byte);
        end
        if (msg.end_of_message) begin
          close_message();
        end
      end
    end
    pending_o = digest_q.size();
  end

endmodule

// ===== tb/tb_sha256_stream_hasher_unit.sv =====
// top of the sha-256 stream hasher testbench: clock, reset, message stimulus,
// digest back-pressure and verdict; uses shs_if, the hasher and shs_digest_checker
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_unit;

  localparam int ItemTarget = 450;
  localparam int LongLens [5] = '{64, 56, 55, 63, 120};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  shs_in_if  msg_if ();
  shs_out_if dig_if ();

  int fail_count;
  int pending_beats;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;

  sha256_stream_hasher_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  shs_digest_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg          (msg_if),
    .dig          (dig_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // digest side back-pressure
  always @(posedge clk_i) begin
    dig_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one message beat, after a random idle gap; valid stays up when there is no gap
  task automatic send_beat(input logic [7:0] data, input logic present, input logic eom);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= data;
    msg_if.byte_present   <= present;
    msg_if.end_of_message <= eom;
    @(posedge clk_i);
    while (!msg_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // random-content message, closed on its last byte or by a bare end beat,
  // with the odd bare idle beat mixed in as noise
  task automatic send_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
      items_sent++;
    end
    if (len == 0 || bare_end) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin
    int msg_no;
    int len;
    msg_no                = 0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = 8'h00;
    msg_if.byte_present   = 1'b0;
    msg_if.end_of_message = 1'b0;
    dig_if.ready          = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle beats, empty message, single extreme bytes, "abc" both ways
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h80, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    items_sent += 11;

    // random messages, every third one at a length near a block or padding boundary
    while (items_sent < ItemTarget) begin
      unique case (items_sent * 4 / ItemTarget)
        0: begin
          sender_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 61; recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  recv_stall_pct = 61;
        end
        default: begin
          sender_idle_pct = 38; recv_stall_pct = 38;
        end
      endcase
      if (msg_no % 3 == 2) begin
        len = LongLens[(msg_no / 3) % 5];
      end else if ($urandom_range(0, 1) == 0) begin
        len = $urandom_range(0, 8);
      end else begin
        len = $urandom_range(9, 40);
      end
      send_message(len, $urandom_range(0, 3) == 0);
      msg_no++;
    end
    msg_if.valid <= 1'b0;

    // drain outstanding digest beats, then watch for stray ones
    @(negedge clk_i);
    @(negedge clk_i);
    while (pending_beats != 0) begin
      @(negedge clk_i);
    end
    repeat (150) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
